// ===== design/ild_pkg.sv =====
// shared types and constants for the ignition line debounce block
package ild_pkg;

    localparam int unsigned CNT_W = 8;
    localparam int unsigned IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_ON_DEB    = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFF_DEB   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SETTLE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_QON_A     = 3'd3;
    localparam logic [IDX_W-1:0] REG_QOFF_A    = 3'd4;
    localparam logic [IDX_W-1:0] REG_QON_B     = 3'd5;
    localparam logic [IDX_W-1:0] REG_QOFF_B    = 3'd6;

    localparam logic [CNT_W-1:0] RST_ON_DEB  = 8'd5;
    localparam logic [CNT_W-1:0] RST_OFF_DEB = 8'd5;
    localparam logic [CNT_W-1:0] RST_SETTLE  = 8'd10;
    localparam logic [CNT_W-1:0] RST_QON_A   = 8'd5;
    localparam logic [CNT_W-1:0] RST_QOFF_A  = 8'd5;
    localparam logic [CNT_W-1:0] RST_QON_B   = 8'd10;
    localparam logic [CNT_W-1:0] RST_QOFF_B  = 8'd10;

    typedef struct packed {
        logic [CNT_W-1:0] on_deb;
        logic [CNT_W-1:0] off_deb;
        logic [CNT_W-1:0] settle;
        logic [CNT_W-1:0] qon_a;
        logic [CNT_W-1:0] qoff_a;
        logic [CNT_W-1:0] qon_b;
        logic [CNT_W-1:0] qoff_b;
    } ild_cfg_t;

    typedef struct packed {
        logic on_to_off_b;
        logic off_to_on_b;
        logic on_to_off_a;
        logic off_to_on_a;
        logic static_on;
        logic stable;
        logic level;
    } ild_flags_t;

    typedef struct packed {
        logic up;
        logic down;
    } ild_qflags_t;

endpackage

// ===== design/ild_cfg.sv =====
// configuration register file for the debounce reload counts
module ild_cfg
    import ild_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CNT_W-1:0] wr_data,
    output ild_cfg_t         cfg
);

    ild_cfg_t cfg_reg;
    ild_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_ON_DEB:  cfg_next.on_deb  = wr_data;
                REG_OFF_DEB: cfg_next.off_deb = wr_data;
                REG_SETTLE:  cfg_next.settle  = wr_data;
                REG_QON_A:   cfg_next.qon_a   = wr_data;
                REG_QOFF_A:  cfg_next.qoff_a  = wr_data;
                REG_QON_B:   cfg_next.qon_b   = wr_data;
                REG_QOFF_B:  cfg_next.qoff_b  = wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{on_deb: RST_ON_DEB, off_deb: RST_OFF_DEB, settle: RST_SETTLE,
                         qon_a: RST_QON_A, qoff_a: RST_QOFF_A,
                         qon_b: RST_QON_B, qoff_b: RST_QOFF_B};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ild_qual.sv =====
// one off-to-on / on-to-off qualifier pair with its two counters
module ild_qual
    import ild_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             level,
    input  logic [CNT_W-1:0] on_reload,
    input  logic [CNT_W-1:0] off_reload,
    input  logic [CNT_W-1:0] on_rst,
    input  logic [CNT_W-1:0] off_rst,
    output ild_qflags_t      flags_next
);

    logic [CNT_W-1:0] on_cnt_reg;
    logic [CNT_W-1:0] on_cnt_next;
    logic [CNT_W-1:0] off_cnt_reg;
    logic [CNT_W-1:0] off_cnt_next;
    ild_qflags_t      flags_reg;

    always_comb begin
        on_cnt_next  = on_cnt_reg;
        off_cnt_next = off_cnt_reg;
        flags_next   = flags_reg;
        if (!level) begin
            if (off_cnt_reg != '0) begin
                off_cnt_next    = off_cnt_reg - 1'b1;
                on_cnt_next     = on_reload;
                flags_next.down = 1'b0;
            end else begin
                flags_next.down = 1'b1;
                flags_next.up   = 1'b0;
            end
        end else begin
            if (on_cnt_reg != '0) begin
                on_cnt_next     = on_cnt_reg - 1'b1;
                off_cnt_next    = off_reload;
                flags_next.up   = 1'b0;
            end else begin
                flags_next.up   = 1'b1;
                flags_next.down = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_cnt_reg  <= on_rst;
            off_cnt_reg <= off_rst;
            flags_reg   <= '0;
        end else if (step) begin
            on_cnt_reg  <= on_cnt_next;
            off_cnt_reg <= off_cnt_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

// ===== design/ild_core.sv =====
// level tracking, static-on debounce, settle countdown and both qualifier pairs
module ild_core
    import ild_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [2:0] lines,
    input  ild_cfg_t   cfg,
    output ild_flags_t flags_next,
    output logic       level_chg
);

    logic             level;
    logic             level_reg;
    logic             stable_reg;
    logic             stable_next;
    logic             static_on_reg;
    logic             static_on_next;
    logic [CNT_W-1:0] on_cnt_reg;
    logic [CNT_W-1:0] on_cnt_next;
    logic [CNT_W-1:0] off_cnt_reg;
    logic [CNT_W-1:0] off_cnt_next;
    logic [CNT_W-1:0] settle_reg;
    logic [CNT_W-1:0] settle_next;
    logic [CNT_W-1:0] settle_eff;
    logic             stable_eff;
    ild_qflags_t      qa_next;
    ild_qflags_t      qb_next;

    assign level     = |lines;
    assign level_chg = level != level_reg;

    always_comb begin
        settle_eff  = level_chg ? cfg.settle : settle_reg;
        stable_eff  = level_chg ? 1'b0 : stable_reg;
        settle_next = settle_eff;
        stable_next = stable_eff;
        if (settle_eff != '0) begin
            settle_next = settle_eff - 1'b1;
        end else begin
            stable_next = 1'b1;
        end
    end

    always_comb begin
        on_cnt_next    = on_cnt_reg;
        off_cnt_next   = off_cnt_reg;
        static_on_next = static_on_reg;
        if (level) begin
            if (on_cnt_reg != '0) begin
                on_cnt_next  = on_cnt_reg - 1'b1;
                off_cnt_next = cfg.off_deb;
            end else begin
                static_on_next = 1'b1;
            end
        end else begin
            if (off_cnt_reg != '0) begin
                off_cnt_next = off_cnt_reg - 1'b1;
                on_cnt_next  = cfg.on_deb;
            end else begin
                static_on_next = 1'b0;
            end
        end
    end

    ild_qual u_qual_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .level      (level),
        .on_reload  (cfg.qon_a),
        .off_reload (cfg.qoff_a),
        .on_rst     (RST_QON_A),
        .off_rst    (RST_QOFF_A),
        .flags_next (qa_next)
    );

    ild_qual u_qual_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .level      (level),
        .on_reload  (cfg.qon_b),
        .off_reload (cfg.qoff_b),
        .on_rst     (RST_QON_B),
        .off_rst    (RST_QOFF_B),
        .flags_next (qb_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= 1'b0;
            stable_reg    <= 1'b0;
            static_on_reg <= 1'b0;
            on_cnt_reg    <= RST_ON_DEB;
            off_cnt_reg   <= RST_OFF_DEB;
            settle_reg    <= RST_SETTLE;
        end else if (step) begin
            level_reg     <= level;
            stable_reg    <= stable_next;
            static_on_reg <= static_on_next;
            on_cnt_reg    <= on_cnt_next;
            off_cnt_reg   <= off_cnt_next;
            settle_reg    <= settle_next;
        end
    end

    assign flags_next = '{on_to_off_b: qb_next.down, off_to_on_b: qb_next.up,
                          on_to_off_a: qa_next.down, off_to_on_a: qa_next.up,
                          static_on: static_on_next, stable: stable_next,
                          level: level};

endmodule

// ===== design/ignition_line_debounce.sv =====
// top level: ignition debounce with input register, core and result register
//
// channel  direction  ports                       content
// s_       in         s_tvalid s_tready s_tdata   one tick with three ignition source lines
// m_       out        m_tvalid m_tready m_tdata   level, stable, static-on, qualifier flags
// cfg_     in         cfg_wr_en cfg_index cfg_wdata  reload counts, indexes 0 to 6
//
// one tick per cycle sustained while m_tready is high; a tick reaches m_tdata through the
// input register, then the counter update into the result register
// reset is synchronous on aresetn and loads the default reload counts
// the input register holds while the result register is stalled; s_tready stays high
// while the input register is empty or moving on
module ignition_line_debounce
    import ild_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // hw_line, bus_line, remote_line, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // ign_level, ign_stable, ign_static_on, off_to_on_a,
                                        // on_to_off_a, off_to_on_b, on_to_off_b, zero pad
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0] cfg_wdata
);

    ild_cfg_t   cfg;
    ild_flags_t flags_next;
    ild_flags_t out_flags_reg;
    logic       in_valid_reg;
    logic [2:0] in_lines_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       step;
    logic       level_chg;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    ild_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    ild_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .lines      (in_lines_reg),
        .cfg        (cfg),
        .flags_next (flags_next),
        .level_chg  (level_chg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_lines_reg <= s_tdata[2:0];
        end
        if (step) begin
            out_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_flags_reg};

`ifndef SYNTH
    a_pair_a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_flags_reg.off_to_on_a && out_flags_reg.on_to_off_a))
        else $error("qualifier pair a flags both set");

    a_pair_b_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_flags_reg.off_to_on_b && out_flags_reg.on_to_off_b))
        else $error("qualifier pair b flags both set");

    a_chg_unstable: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && level_chg && (cfg.settle != '0)) |=> !out_flags_reg.stable)
        else $error("stable set on a level change");

    a_step_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("tick taken into core without a result");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the ignition line debounce block, directed ticks then random runs
module tb_top;
    import ild_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned MAX_PRINTS  = 100;
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;   // no register behind this index

    typedef enum int {CFG_MIX, CFG_ZERO, CFG_FULL} cfg_mode_e;

    typedef struct packed {
        logic [2:0] lines;    // hw_line, bus_line, remote_line from bit 0 up
        logic       typed;
        ild_flags_t flags;
    } tick_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;  // hw_line, bus_line, remote_line, zero pad
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;         // ign_level, ign_stable, ign_static_on, off_to_on_a,
                                       // on_to_off_a, off_to_on_b, on_to_off_b, zero pad
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    ignition_line_debounce dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // predictor state
    ild_cfg_t         reload;
    logic             lvl_q;
    logic             stable_q;
    logic             static_on_q;
    logic [CNT_W-1:0] on_cnt;
    logic [CNT_W-1:0] off_cnt;
    logic [CNT_W-1:0] settle_cnt;
    logic [CNT_W-1:0] qual_cnt [4];
    logic             qual_flag [4];

    ild_flags_t  flags_due [$];
    int unsigned err_count  = 0;
    int unsigned cycle_cnt  = 0;
    bit          steady_src  = 0;
    bit          steady_sink = 0;
    bit          hold_req    = 0;

    string field_name [7] = '{"ign_level", "ign_stable", "ign_static_on", "off_to_on_a",
                              "on_to_off_a", "off_to_on_b", "on_to_off_b"};

    tick_row_t directed_ticks [24] = '{
        '{3'b000, 1'b1, 7'd0}, '{3'b000, 1'b1, 7'd0},
        '{3'b001, 1'b0, 7'd0}, '{3'b000, 1'b0, 7'd0},
        '{3'b010, 1'b0, 7'd0}, '{3'b000, 1'b0, 7'd0},
        '{3'b100, 1'b0, 7'd0}, '{3'b000, 1'b0, 7'd0},
        '{3'b011, 1'b0, 7'd0}, '{3'b101, 1'b0, 7'd0},
        '{3'b110, 1'b0, 7'd0}, '{3'b111, 1'b0, 7'd0},
        '{3'b001, 1'b0, 7'd0}, '{3'b010, 1'b0, 7'd0},
        '{3'b100, 1'b0, 7'd0}, '{3'b111, 1'b0, 7'd0},
        '{3'b011, 1'b0, 7'd0}, '{3'b101, 1'b0, 7'd0},
        '{3'b110, 1'b0, 7'd0}, '{3'b111, 1'b0, 7'd0},
        '{3'b000, 1'b0, 7'd0}, '{3'b000, 1'b0, 7'd0},
        '{3'b000, 1'b0, 7'd0}, '{3'b000, 1'b0, 7'd0}
    };

    task automatic report_fault(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic reset_predictor();
        reload = '{RST_ON_DEB, RST_OFF_DEB, RST_SETTLE, RST_QON_A, RST_QOFF_A,
                   RST_QON_B, RST_QOFF_B};
        lvl_q       = 1'b0;
        stable_q    = 1'b0;
        static_on_q = 1'b0;
        on_cnt      = RST_ON_DEB;
        off_cnt     = RST_OFF_DEB;
        settle_cnt  = RST_SETTLE;
        qual_cnt    = '{RST_QON_A, RST_QOFF_A, RST_QON_B, RST_QOFF_B};
        qual_flag   = '{1'b0, 1'b0, 1'b0, 1'b0};
    endtask

    // slot up holds the on count and off-to-on flag, slot up+1 the off side
    task automatic qualify_pair(input int up, input logic [CNT_W-1:0] on_reload,
                                input logic [CNT_W-1:0] off_reload);
        int dn;
        dn = up + 1;
        if (!lvl_q) begin
            if (qual_cnt[dn] != 0) begin
                qual_cnt[dn]  = qual_cnt[dn] - 8'd1;
                qual_cnt[up]  = on_reload;
                qual_flag[dn] = 1'b0;
            end else begin
                qual_flag[dn] = 1'b1;
                qual_flag[up] = 1'b0;
            end
        end else begin
            if (qual_cnt[up] != 0) begin
                qual_cnt[up]  = qual_cnt[up] - 8'd1;
                qual_cnt[dn]  = off_reload;
                qual_flag[up] = 1'b0;
            end else begin
                qual_flag[up] = 1'b1;
                qual_flag[dn] = 1'b0;
            end
        end
    endtask

    task automatic debounce_tick(input logic [2:0] lines, output ild_flags_t res);
        logic lvl;
        lvl = |lines;
        if (lvl != lvl_q) begin
            lvl_q      = lvl;
            stable_q   = 1'b0;
            settle_cnt = reload.settle;
        end
        if (lvl_q) begin
            if (on_cnt != 0) begin
                on_cnt  = on_cnt - 8'd1;
                off_cnt = reload.off_deb;
            end else begin
                static_on_q = 1'b1;
            end
        end else begin
            if (off_cnt != 0) begin
                off_cnt = off_cnt - 8'd1;
                on_cnt  = reload.on_deb;
            end else begin
                static_on_q = 1'b0;
            end
        end
        if (settle_cnt != 0)
            settle_cnt = settle_cnt - 8'd1;
        else
            stable_q = 1'b1;
        qualify_pair(0, reload.qon_a, reload.qoff_a);
        qualify_pair(2, reload.qon_b, reload.qoff_b);
        res.level       = lvl_q;
        res.stable      = stable_q;
        res.static_on   = static_on_q;
        res.off_to_on_a = qual_flag[0];
        res.on_to_off_a = qual_flag[1];
        res.off_to_on_b = qual_flag[2];
        res.on_to_off_b = qual_flag[3];
    endtask

    function automatic int idle_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CNT_W-1:0] pick_reload(input cfg_mode_e mode);
        case (mode)
            CFG_ZERO: return '0;
            CFG_FULL: return '1;
            default: begin
                if ($urandom_range(0, 7) == 0)
                    return CNT_W'($urandom_range(0, 255));
                return CNT_W'($urandom_range(0, 10));
            end
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_ON_DEB: reload.on_deb  = val;
            REG_OFF_DEB: reload.off_deb = val;
            REG_SETTLE: reload.settle  = val;
            REG_QON_A: reload.qon_a   = val;
            REG_QOFF_A: reload.qoff_a  = val;
            REG_QON_B: reload.qon_b   = val;
            REG_QOFF_B: reload.qoff_b  = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input cfg_mode_e mode);
        write_reg(REG_ON_DEB, pick_reload(mode));
        write_reg(REG_OFF_DEB, pick_reload(mode));
        write_reg(REG_SETTLE, pick_reload(mode));
        write_reg(REG_QON_A, pick_reload(mode));
        write_reg(REG_QOFF_A, pick_reload(mode));
        write_reg(REG_QON_B, pick_reload(mode));
        write_reg(REG_QOFF_B, pick_reload(mode));
        write_reg(REG_NONE, CNT_W'($urandom_range(0, 255)));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic offer_tick(input logic [2:0] lines, input logic typed,
                              input ild_flags_t typed_flags);
        int gap;
        ild_flags_t nxt;
        gap = idle_gap(steady_src);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, lines};
        do @(posedge aclk); while (!s_tready);
        debounce_tick(lines, nxt);
        flags_due.push_back(typed ? typed_flags : nxt);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (flags_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [CNT_W-1:0] longest_reload();
        logic [CNT_W-1:0] m;
        m = reload.on_deb;
        if (reload.off_deb > m) m = reload.off_deb;
        if (reload.settle > m) m = reload.settle;
        if (reload.qon_a > m) m = reload.qon_a;
        if (reload.qoff_a > m) m = reload.qoff_a;
        if (reload.qon_b > m) m = reload.qon_b;
        if (reload.qoff_b > m) m = reload.qoff_b;
        return m;
    endfunction

    // runs of one level with random source mix; short runs act as glitches
    task automatic random_runs(input int count, input int hold_at);
        int sent;
        int run_len;
        int r;
        int top;
        logic on;
        sent = 0;
        while (sent < count) begin
            top = int'(longest_reload());
            on  = 1'($urandom_range(0, 1));
            r   = $urandom_range(0, 99);
            if (r < 70)
                run_len = $urandom_range(1, top + 3);
            else if (r < 95)
                run_len = $urandom_range(1, 4);
            else
                run_len = $urandom_range(top, top + 30);
            if (run_len > count - sent)
                run_len = count - sent;
            repeat (run_len) begin
                if (sent == hold_at)
                    hold_req = 1;
                offer_tick(on ? 3'($urandom_range(1, 7)) : 3'b000, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        ild_flags_t want;
        ild_flags_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[6:0];
            if (flags_due.size() == 0) begin
                report_fault($sformatf("result transfer 0x%02h with no tick pending", m_tdata));
            end else begin
                want = flags_due.pop_front();
                for (int i = 0; i < 7; i++)
                    if (got[i] !== want[i])
                        report_fault($sformatf("%s expected %0b got %0b",
                                               field_name[i], want[i], got[i]));
            end
        end
    end

    initial begin : sink
        int n;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (steady_sink || $urandom_range(0, 99) < 65) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin : source
        cfg_mode_e mode;
        int count;
        reset_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_ticks[i])
            offer_tick(directed_ticks[i].lines, directed_ticks[i].typed,
                       directed_ticks[i].flags);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            mode  = (p == 1) ? CFG_ZERO : (p == 3) ? CFG_FULL : CFG_MIX;
            count = (mode == CFG_FULL) ? 500 : 125;
            steady_src  = (p % 4 == 2);
            steady_sink = (p % 5 == 4);
            program_regs(mode);
            random_runs(count, (p == 2) ? 40 : -1);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
